// File: hdl/gtj_pkg.sv
// Package for the greedy text justifier: shared constants and the divider
// request and result structs. No dependencies.
package gtj_pkg;

   localparam int MAX_WIDTH_DEF = 32;
   localparam int CHAR_W = 8;
   localparam int CSR_W = 6;
   localparam int DIV_W = 6;
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
   localparam logic [CSR_W-1:0] WIDTH_RESET = 6'd16;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

// File: hdl/gtj_divider.sv
// Restoring divider, one quotient bit per cycle, used to split gap spaces.
// Depends on gtj_pkg.
module gtj_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gtj_pkg::div_req_type req,
   output gtj_pkg::div_rsp_type rsp
);
   localparam int W = gtj_pkg::DIV_W;
   localparam int NW = $clog2(W + 1);

   logic [W-1:0]  rem_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  den_ff;
   logic [NW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [W:0]    trial;

   assign trial = {rem_ff, quo_ff[W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff <= '0;
            quo_ff <= req.num;
            den_ff <= req.den;
            cnt_ff <= NW'(W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= W'(trial - {1'b0, den_ff});
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;
   assign rsp.rem = rem_ff;

endmodule

// File: hdl/greedy_text_justifier_unit.sv
// Top level of the greedy text justifier: word and line memories, sequencer
// and output register. Depends on gtj_pkg and gtj_divider.

// Characters are taken one per transaction while the block is idle. A word
// end copies the word into the line memory one character at a time and then
// updates the line counts; a line that must go out first is emitted before
// the copy: the divider splits the spaces when its gaps are justified, each
// letter takes a line memory read and an output, each space an output, and
// the rest of the line is padding. The line memory read port and the single
// output register set this pacing; a stalled output holds the sequencer.
module greedy_text_justifier_unit #(
   parameter int MAX_WIDTH = gtj_pkg::MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code
   input  logic        req_tlast,   // word_end
   input  logic        req_tuser,   // text_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_char
   output logic        rsp_tlast,   // line_end
   output logic [2:0]  rsp_tuser,   // text_done, truncated, burst_end
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int DW = gtj_pkg::DIV_W;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_LREAD, S_LDATA, S_SPACE, S_PAD, S_COPY, S_CEND
   } state_type;

   state_type state_ff;
   logic [5:0]    width_ff;
   logic [CW-1:0] wlen_ff, letters_ff, words_ff, len_ff, cidx_ff;
   logic [CW-1:0] pos_ff, idx_ff, wnum_ff, sp_ff, base_ff, extra_ff;
   logic          wov_ff, lov_ff, te_ff, final_ff;
   logic          pend_ff, pend_mark_ff;
   logic [AW-1:0] pend_addr_ff;

   logic [7:0] word_mem [MAX_WIDTH];
   logic [8:0] line_mem [MAX_WIDTH];
   logic [7:0] word_rd_ff;
   logic [8:0] line_rd_ff;

   logic       rsp_valid_ff, rsp_last_ff, rsp_done_ff, rsp_trunc_ff, rsp_burst_ff;
   logic [7:0] rsp_char_ff;

   gtj_pkg::div_req_type div_req;
   gtj_pkg::div_rsp_type div_rsp;

   logic [CW-1:0] w, gaps_c, wl_new, len_c;
   logic          accept, we, wfits, ov_new, just_c, need_emit, slot_free, last_c;
   logic [CW+1:0] fit_sum;

   always_comb begin
      if (width_ff == 6'd0) w = CW'(1);
      else if (width_ff > 6'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
      else w = width_ff[CW-1:0];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign we = req_tlast || req_tuser;
   assign wfits = wlen_ff < w;
   assign wl_new = wfits ? wlen_ff + CW'(1) : wlen_ff;
   assign ov_new = wov_ff || !wfits;
   assign len_c = (wl_new > w) ? w : wl_new;
   assign gaps_c = (words_ff == '0) ? '0 : words_ff - CW'(1);
   assign just_c = (gaps_c != '0) &&
                   ({1'b0, letters_ff} + {1'b0, gaps_c} <= {1'b0, w});
   assign fit_sum = (CW+2)'(letters_ff) + (CW+2)'(words_ff) + (CW+2)'(len_c);
   assign need_emit = (words_ff != '0) && (fit_sum > (CW+2)'(w));
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign last_c = (pos_ff == w - CW'(1));

   assign div_req.start = accept && we && need_emit && just_c;
   assign div_req.num = DW'(w - letters_ff);
   assign div_req.den = DW'(gaps_c);

   gtj_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Word memory: written on accept while the word fits, read during the copy.
   always_ff @(posedge clock) begin
      if (accept && wfits) word_mem[wlen_ff[AW-1:0]] <= req_tdata;
      if (state_ff == S_COPY) word_rd_ff <= word_mem[cidx_ff[AW-1:0]];
   end

   // Line memory: written in the cycle after each word read, read by the emitter.
   always_ff @(posedge clock) begin
      if (pend_ff) line_mem[pend_addr_ff] <= {pend_mark_ff, word_rd_ff};
      if (state_ff == S_LREAD && idx_ff < letters_ff)
         line_rd_ff <= line_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      logic put;
      logic [7:0] ch;
      put = 1'b0;
      ch = gtj_pkg::SPACE_CHAR;
      if (reset) begin
         state_ff <= S_IDLE;
         width_ff <= gtj_pkg::WIDTH_RESET;
         wlen_ff <= '0;
         wov_ff <= 1'b0;
         letters_ff <= '0;
         words_ff <= '0;
         lov_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) width_ff <= csr_wdata;
         pend_ff <= 1'b0;
         if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (!we) begin
                     wlen_ff <= wl_new;
                     wov_ff <= ov_new;
                  end else begin
                     len_ff <= len_c;
                     wov_ff <= ov_new || (wl_new > w);
                     te_ff <= req_tuser;
                     cidx_ff <= '0;
                     pos_ff <= '0;
                     idx_ff <= '0;
                     wnum_ff <= '0;
                     final_ff <= 1'b0;
                     base_ff <= CW'(1);
                     extra_ff <= '0;
                     if (!need_emit) state_ff <= S_COPY;
                     else if (just_c) state_ff <= S_DIV;
                     else state_ff <= S_LREAD;
                  end
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  base_ff <= CW'(div_rsp.quo);
                  extra_ff <= CW'(div_rsp.rem);
                  state_ff <= S_LREAD;
               end
            end
            S_LREAD: begin
               state_ff <= (idx_ff < letters_ff) ? S_LDATA : S_PAD;
            end
            S_LDATA: begin
               if (slot_free) begin
                  put = 1'b1;
                  ch = line_rd_ff[7:0];
                  idx_ff <= idx_ff + CW'(1);
                  if (line_rd_ff[8]) wnum_ff <= wnum_ff + CW'(1);
                  if (line_rd_ff[8] && wnum_ff < gaps_c) begin
                     sp_ff <= base_ff + ((wnum_ff < extra_ff) ? CW'(1) : CW'(0));
                     state_ff <= S_SPACE;
                  end else begin
                     state_ff <= S_LREAD;
                  end
               end
            end
            S_SPACE: begin
               if (slot_free) begin
                  put = 1'b1;
                  sp_ff <= sp_ff - CW'(1);
                  if (sp_ff == CW'(1)) state_ff <= S_LREAD;
               end
            end
            S_PAD: begin
               if (slot_free) put = 1'b1;
            end
            S_COPY: begin
               pend_ff <= 1'b1;
               pend_addr_ff <= AW'(letters_ff + cidx_ff);
               pend_mark_ff <= (cidx_ff == len_ff - CW'(1));
               cidx_ff <= cidx_ff + CW'(1);
               if (cidx_ff == len_ff - CW'(1)) state_ff <= S_CEND;
            end
            S_CEND: begin
               letters_ff <= letters_ff + len_ff;
               words_ff <= words_ff + CW'(1);
               lov_ff <= lov_ff || wov_ff;
               wlen_ff <= '0;
               wov_ff <= 1'b0;
               if (te_ff) begin
                  final_ff <= 1'b1;
                  base_ff <= CW'(1);
                  extra_ff <= '0;
                  pos_ff <= '0;
                  idx_ff <= '0;
                  wnum_ff <= '0;
                  state_ff <= S_LREAD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (put) begin
            rsp_valid_ff <= 1'b1;
            rsp_char_ff <= ch;
            rsp_last_ff <= last_c;
            rsp_done_ff <= last_c && final_ff;
            rsp_trunc_ff <= lov_ff;
            rsp_burst_ff <= last_c && (final_ff || !te_ff);
            pos_ff <= pos_ff + CW'(1);
            if (last_c) begin
               letters_ff <= '0;
               words_ff <= '0;
               lov_ff <= 1'b0;
               cidx_ff <= '0;
               state_ff <= final_ff ? S_IDLE : S_COPY;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_char_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = {rsp_burst_ff, rsp_trunc_ff, rsp_done_ff};

   a_done_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tuser[2])
      else $error("text_done without line and burst end");

   a_letters_bound: assert property (@(posedge clock) disable iff (reset)
      letters_ff <= CW'(MAX_WIDTH))
      else $error("line letter count beyond capacity");

   a_pos_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LDATA || state_ff == S_SPACE || state_ff == S_PAD) |-> pos_ff < w)
      else $error("emit position past line width");

endmodule
